// ===== rtl/pixel_saturation_adjust_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pixel saturation block
// Shared concurrent assertion forms, clocked and reset-gated.
// ---------------------------------------------------------------------------
`ifndef PIXEL_SATURATION_ADJUST_ASSERT_SVH
`define PIXEL_SATURATION_ADJUST_ASSERT_SVH

// same-cycle implication
`define PSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define PSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/psa_pkg.sv =====
// ---------------------------------------------------------------------------
// psa_pkg
// Widths, constants and shared types of the saturation adjust pipeline.
// ---------------------------------------------------------------------------
package psa_pkg;

	localparam int RATIO_FRAC_BITS = 16;
	localparam int F = RATIO_FRAC_BITS;

	// ratio in Q.F with room for exactly 1.0
	localparam int ONE_W = F + 1;
	// long division operands
	localparam int NUM_W = 2 * F + 1;
	localparam int DEN_W = F + 1;
	localparam int ALPHA_W = 2 * F;
	localparam int DIFF_W = 11;
	localparam int BASE_W = F + 10;
	localparam int PROD_W = DIFF_W + ALPHA_W + 1;
	localparam int ACC_W = PROD_W + 1;

	localparam logic [6:0] INC_MAX = 7'd100;

	// floor(mag * 2^F / 100) as a multiply by reciprocal
	localparam int RECIP_SH = 14;
	localparam int RECIP_W = F + 8;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << (F + RECIP_SH)) + 64'd99) / 64'd100);

	localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << F;

	typedef struct packed {
		logic       valid;
		logic       gray;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic [8:0] sum;
	} psa_side_t;

endpackage

// ===== rtl/psa_div.sv =====
// ---------------------------------------------------------------------------
// psa_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ---------------------------------------------------------------------------
module psa_div
	import psa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ce,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  psa_side_t        side_in,
	output logic [NUM_W-1:0] quo,
	output psa_side_t        side_out
);

	logic [DEN_W-1:0] rem_s  [NUM_W];
	logic [NUM_W-1:0] num_s  [NUM_W];
	logic [NUM_W-1:0] quo_s  [NUM_W];
	logic [DEN_W-1:0] den_s  [NUM_W];
	psa_side_t        side_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W-1:0] rem_prev;
		logic [NUM_W-1:0] num_prev;
		logic [NUM_W-1:0] quo_prev;
		logic [DEN_W-1:0] den_prev;
		psa_side_t        side_prev;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   rest;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_prev  = '0;
			assign num_prev  = num;
			assign quo_prev  = '0;
			assign den_prev  = den;
			assign side_prev = side_in;
		end else begin : g_next
			assign rem_prev  = rem_s[i-1];
			assign num_prev  = num_s[i-1];
			assign quo_prev  = quo_s[i-1];
			assign den_prev  = den_s[i-1];
			assign side_prev = side_s[i-1];
		end

		always_comb begin
			trial = {rem_prev, num_prev[NUM_W-1]};
			ge    = trial >= {1'b0, den_prev};
			rest  = ge ? trial - {1'b0, den_prev} : trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[i] <= '0;
			end else if (ce) begin
				side_s[i] <= side_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[i] <= rest[DEN_W-1:0];
				num_s[i] <= num_prev << 1;
				quo_s[i] <= {quo_prev[NUM_W-2:0], ge};
				den_s[i] <= den_prev;
			end
		end
	end

	assign quo      = quo_s[NUM_W-1];
	assign side_out = side_s[NUM_W-1];

endmodule

// ===== rtl/pixel_saturation_adjust.sv =====
// The two long dividers retire one quotient bit per stage; stage 3 lies between them.
// Throughput: one pixel per cycle unless the output stalls.
// A stalled result freezes every stage, so nothing is lost or repeated.
// Reset clears all valid bits and the increment to zero.
// ---------------------------------------------------------------------------
// pixel_saturation_adjust
// HSL saturation change of one 8-bit BGR pixel per cycle when not stalled, deep pipeline.
// ---------------------------------------------------------------------------
module pixel_saturation_adjust
	import psa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [7:0] wr_data,
	input  logic       pixel_valid,
	output logic       pixel_stall,
	input  logic [7:0] blue_in,
	input  logic [7:0] green_in,
	input  logic [7:0] red_in,
	output logic       adj_valid,
	input  logic       adj_stall,
	output logic [7:0] blue_out,
	output logic [7:0] green_out,
	output logic [7:0] red_out
);

	`include "pixel_saturation_adjust_assert.svh"

	logic ce;
	assign ce = !(adj_valid && adj_stall);
	assign pixel_stall = !ce;

	// increment register, kept as sign and Q.F fraction
	logic             inc_pos_q;
	logic [ONE_W-1:0] q_q;
	logic [6:0]       cfg_mag;
	logic [RECIP_W+6:0] cfg_prod;

	always_comb begin
		if ($signed(wr_data) > $signed({1'b0, INC_MAX}))
			cfg_mag = INC_MAX;
		else if ($signed(wr_data) < -$signed({1'b0, INC_MAX}))
			cfg_mag = INC_MAX;
		else if (wr_data[7])
			cfg_mag = 7'(-wr_data);
		else
			cfg_mag = wr_data[6:0];
		cfg_prod = {{RECIP_W{1'b0}}, cfg_mag} * {7'd0, RECIP};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_pos_q <= 1'b0;
			q_q       <= '0;
		end else if (wr_en) begin
			inc_pos_q <= !wr_data[7] && (wr_data != 8'd0);
			q_q       <= cfg_prod[RECIP_SH +: ONE_W];
		end
	end

	// stage 1: max, min, sum and delta
	logic [7:0] mx, mn;
	logic       valid_s1, gray_s1;
	logic [7:0] b_s1, g_s1, r_s1, delta_s1;
	logic [8:0] sum_s1;

	always_comb begin
		mx = blue_in;
		mn = blue_in;
		if (green_in > mx) mx = green_in;
		if (green_in < mn) mn = green_in;
		if (red_in > mx) mx = red_in;
		if (red_in < mn) mn = red_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			b_s1     <= blue_in;
			g_s1     <= green_in;
			r_s1     <= red_in;
			sum_s1   <= {1'b0, mx} + {1'b0, mn};
			delta_s1 <= mx - mn;
			gray_s1  <= mx == mn;
		end
	end

	// saturation: the larger ratio is the one over the smaller divisor
	psa_side_t        side1;
	logic [8:0]       den1;
	logic [NUM_W-1:0] quo1;
	psa_side_t        side_d1;

	assign side1 = '{valid: valid_s1, gray: gray_s1, b: b_s1, g: g_s1, r: r_s1, sum: sum_s1};
	assign den1  = (sum_s1 <= 9'd255) ? sum_s1 : 9'd510 - sum_s1;

	psa_div u_div_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.num      (NUM_W'(delta_s1) << F),
		.den      (DEN_W'(den1)),
		.side_in  (side1),
		.quo      (quo1),
		.side_out (side_d1)
	);

	// stage 3: m = max(S, 1 - q), never zero
	logic [ONE_W-1:0] sat_r, thr, m_next, m_s3;
	psa_side_t        side_s3;

	always_comb begin
		sat_r  = quo1[ONE_W-1:0];
		thr    = ONE - q_q;
		m_next = (sat_r > thr) ? sat_r : thr;
		if (m_next == '0)
			m_next = ONE_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (ce) begin
			side_s3 <= side_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) m_s3 <= m_next;
	end

	logic [NUM_W-1:0] quo2;
	psa_side_t        side_d2;

	psa_div u_div_alpha (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.num      (NUM_W'(1) << (2 * F)),
		.den      (m_s3),
		.side_in  (side_s3),
		.quo      (quo2),
		.side_out (side_d2)
	);

	// stage 4: factor, per-channel offset from lightness and base term
	logic [NUM_W-1:0]   alpha_full;
	logic [ALPHA_W-1:0] factor_s4;
	logic [7:0]         ch [3];
	logic [DIFF_W-1:0]  diff_s4 [3];
	logic [BASE_W-1:0]  base_s4 [3];
	psa_side_t          side_s4;

	assign alpha_full = quo2 - NUM_W'(ONE);
	assign ch[0] = side_d2.b;
	assign ch[1] = side_d2.g;
	assign ch[2] = side_d2.r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else if (ce) begin
			side_s4 <= side_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			factor_s4 <= inc_pos_q ? alpha_full[ALPHA_W-1:0] : ALPHA_W'(ONE - q_q);
			for (int i = 0; i < 3; i++) begin
				diff_s4[i] <= {2'b00, ch[i], 1'b0} - {2'b00, side_d2.sum};
				base_s4[i] <= inc_pos_q ? BASE_W'(ch[i]) << (F + 1)
				                        : BASE_W'(side_d2.sum) << F;
			end
		end
	end

	// stage 5: multiply offset by factor
	logic signed [PROD_W-1:0] prod_s5 [3];
	logic [BASE_W-1:0]        base_s5 [3];
	psa_side_t                side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5 <= '0;
		end else if (ce) begin
			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				prod_s5[i] <= $signed(diff_s4[i]) * $signed({1'b0, factor_s4});
				base_s5[i] <= base_s4[i];
			end
		end
	end

	// stage 6: add, truncate, clamp to 0..255
	logic [ACC_W-1:0] acc [3];
	logic [7:0]       res [3];
	logic [7:0]       out_s6 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = {prod_s5[i][PROD_W-1], prod_s5[i]}
			       + {{(ACC_W-BASE_W){1'b0}}, base_s5[i]};
			if (acc[i][ACC_W-1])
				res[i] = 8'd0;
			else if (|acc[i][ACC_W-2:F+9])
				res[i] = 8'd255;
			else
				res[i] = acc[i][F+8:F+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_valid <= 1'b0;
		end else if (ce) begin
			adj_valid <= side_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			// gray pixel: pass through
			out_s6[0] <= side_s5.gray ? side_s5.b : res[0];
			out_s6[1] <= side_s5.gray ? side_s5.g : res[1];
			out_s6[2] <= side_s5.gray ? side_s5.r : res[2];
		end
	end

	assign blue_out  = out_s6[0];
	assign green_out = out_s6[1];
	assign red_out   = out_s6[2];

	`PSA_ASSERT_NXT(a_accept_fills_s1, clk, arst_n, pixel_valid && !pixel_stall, valid_s1)
	`PSA_ASSERT_NXT(a_freeze_holds_s1, clk, arst_n, !ce, $stable(valid_s1))
	`PSA_ASSERT_IMP(a_divisor_nonzero, clk, arst_n, side_s3.valid, m_s3 != '0)
	`PSA_ASSERT_IMP(a_alpha_nonneg, clk, arst_n, side_d2.valid && !side_d2.gray, quo2 >= NUM_W'(ONE))

endmodule

// ===== bench/tb_pixel_saturation_adjust.sv =====
// ---------------------------------------------------------------------------
// Saturation adjust pixel bench
// Drives pixels through the saturation block under several increments and
// idle patterns, predicts each adjusted pixel in fixed point and checks it.
// ---------------------------------------------------------------------------
module tb_pixel_saturation_adjust;
	import psa_pkg::*;

	localparam int LATENCY = 2 * (2 * RATIO_FRAC_BITS + 1) + 4;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} pixel_t;

	class pixel_scoreboard;
		pixel_t expected_q[$];
		logic signed [7:0] increment;
		int errors;

		function longint clamp_channel(longint num);
			longint v;
			if (num < 0)
				return 0;
			v = num >>> (RATIO_FRAC_BITS + 1);
			return v > 255 ? 255 : v;
		endfunction

		function pixel_t adjust_pixel(pixel_t px);
			longint ch[3];
			longint one, mx, mn, sum, delta, inc, mag, q, s1, s2, s, m, alpha, k;
			pixel_t res;
			longint o[3];
			one = longint'(1) << RATIO_FRAC_BITS;
			ch[0] = px.b; ch[1] = px.g; ch[2] = px.r;
			mx = ch[0]; mn = ch[0];
			for (int i = 1; i < 3; i++) begin
				if (ch[i] > mx) mx = ch[i];
				if (ch[i] < mn) mn = ch[i];
			end
			if (mx == mn)
				return px;
			sum = mx + mn;
			delta = mx - mn;
			inc = increment;
			if (inc > 100) inc = 100;
			if (inc < -100) inc = -100;
			mag = inc < 0 ? -inc : inc;
			q = (mag * one) / 100;
			if (inc > 0) begin
				s1 = (delta * one) / sum;
				s2 = (delta * one) / (510 - sum);
				s = s1 > s2 ? s1 : s2;
				m = s > one - q ? s : one - q;
				if (m == 0) m = 1;
				alpha = (one * one) / m - one;
				for (int i = 0; i < 3; i++)
					o[i] = clamp_channel(ch[i] * 2 * one + (2 * ch[i] - sum) * alpha);
			end else begin
				k = one - q;
				for (int i = 0; i < 3; i++)
					o[i] = clamp_channel(sum * one + (2 * ch[i] - sum) * k);
			end
			res.b = o[0][7:0]; res.g = o[1][7:0]; res.r = o[2][7:0];
			return res;
		endfunction

		function void note_pixel(pixel_t px);
			expected_q.push_back(adjust_pixel(px));
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word b=%0d g=%0d r=%0d", $time, got.b, got.g, got.r);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.b !== want.b) begin
				$display("%0t: blue expected %0d actual %0d", $time, want.b, got.b);
				errors++;
			end
			if (got.g !== want.g) begin
				$display("%0t: green expected %0d actual %0d", $time, want.g, got.g);
				errors++;
			end
			if (got.r !== want.r) begin
				$display("%0t: red expected %0d actual %0d", $time, want.r, got.r);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	logic [7:0] wr_data = 0;
	logic pixel_valid = 0;
	logic pixel_stall;
	logic [7:0] blue_in = 0, green_in = 0, red_in = 0;
	logic adj_valid;
	logic adj_stall = 0;
	logic [7:0] blue_out, green_out, red_out;
	logic signed [7:0] settings[8] = '{100, -100, 127, -128, 1, -1, 50, -37};

	pixel_saturation_adjust dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_data(wr_data),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
		.blue_in(blue_in), .green_in(green_in), .red_in(red_in),
		.adj_valid(adj_valid), .adj_stall(adj_stall),
		.blue_out(blue_out), .green_out(green_out), .red_out(red_out)
	);

	pixel_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// receiver: random stall, check on accept
	always @(posedge clk) begin
		if (arst_n && adj_valid && !adj_stall)
			sb.check_pixel('{b: blue_out, g: green_out, r: red_out});
		adj_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (adj_valid && !adj_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_pixel_saturation_adjust: FAIL");
			$finish;
		end
	end

	task automatic write_increment(logic signed [7:0] value);
		wr_en <= 1;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 0;
		sb.increment = value;
	endtask

	task automatic drain();
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 0;
			@(posedge clk);
		end
		pixel_valid <= 1;
		blue_in <= b; green_in <= g; red_in <= r;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		sb.note_pixel('{b: b, g: g, r: r});
	endtask

	task automatic send_random(int count);
		logic [7:0] b, g, r;
		for (int i = 0; i < count; i++) begin
			b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
			case ($urandom_range(9))
				0: begin g = b; r = b; end
				1: begin b = 0; r = 255; end
				2: g = b ^ 8'h01;
				default: ;
			endcase
			send_pixel(b, g, r);
		end
		pixel_valid <= 0;
	endtask

	initial begin
		sb.errors = 0;
		sb.increment = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset increment, extremes, gray, full contrast
		send_pixel(0, 0, 0);
		send_pixel(255, 255, 255);
		send_pixel(0, 128, 255);
		send_pixel(255, 0, 0);
		send_pixel(1, 0, 0);
		pixel_valid <= 0;
		drain();
		foreach (settings[j]) begin
			write_increment(settings[j]);
			send_pixel(128, 128, 128);
			send_pixel(0, 0, 255);
			send_pixel(255, 254, 254);
			send_pixel(10, 200, 90);
			send_pixel(128, 127, 129);
			send_pixel(170, 85, 255);
			pixel_valid <= 0;
			drain();
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 13 : (phase == 1 ? 53 : 0);
			recv_idle_pct = phase == 0 ? 53 : (phase == 1 ? 13 : 0);
			for (int j = 0; j < 3; j++) begin
				write_increment(8'($urandom_range(255)));
				send_random(45);
				drain();
				write_increment(settings[3'($urandom_range(7))]);
				send_random(45);
				drain();
			end
		end
		recv_idle_pct = 0;
		drain();
		if (sb.errors == 0)
			$display("tb_pixel_saturation_adjust: PASS");
		else
			$display("tb_pixel_saturation_adjust: FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/psa_pkg.sv
rtl/psa_div.sv
rtl/pixel_saturation_adjust.sv
bench/tb_pixel_saturation_adjust.sv
